[rtl/bpa_pkg.sv]
// Package for the bitmap page allocator: widths, action and status codes,
// state encoding and the structs that pass between the sequencer and the map store.
// Depends on nothing.
package bpa_pkg;

   localparam int NUM_PAGES = 1048576;

   localparam int PAGE_W  = 20;                  // page index width
   localparam int CNT_W   = 21;                  // page count width
   localparam int BIT_W   = 6;                   // page within one map word
   localparam int LANE_W  = 64;                  // bits in one map word
   localparam int WORD_W  = PAGE_W - BIT_W;      // map word address
   localparam int COL_W   = 6;                   // map word within one summary row
   localparam int ROW_W   = WORD_W - COL_W;      // summary row address
   localparam int CHUNK_W = ROW_W - BIT_W;       // 64-bit chunk of the row flags
   localparam int MAP_WORDS = 1 << WORD_W;
   localparam int SUM_ROWS  = 1 << ROW_W;

   localparam logic [CNT_W-1:0] NUM_PAGES_C = CNT_W'(NUM_PAGES);

   typedef enum logic [1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_FREE    = 2'd1,
      ACT_ADD     = 2'd2,
      ACT_RESERVE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_OOM   = 2'd1,
      ST_RANGE = 2'd2,
      ST_SAME  = 2'd3
   } status_type;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_TOP   = 8'b0000_0010,
      S_SUMW  = 8'b0000_0100,
      S_SUMF  = 8'b0000_1000,
      S_MAPW  = 8'b0001_0000,
      S_MAPF  = 8'b0010_0000,
      S_APPLY = 8'b0100_0000,
      S_RESP  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic              we;
      logic [LANE_W-1:0] map_data;
      logic [LANE_W-1:0] sum_data;
   } store_wr_type;

   typedef struct packed {
      logic [LANE_W-1:0] map_word;
      logic [LANE_W-1:0] sum_word;
   } store_rd_type;

endpackage

[rtl/bpa_req_if.sv]
// Request channel of the bitmap page allocator: valid, ready and one request beat.
// Depends on bpa_pkg.
interface bpa_req_if;
   logic                           valid;
   logic                           ready;
   bpa_pkg::action_type            action;
   logic [bpa_pkg::PAGE_W-1:0]     page_number;

   modport source (output valid, output action, output page_number, input ready);
   modport sink   (input valid, input action, input page_number, output ready);
endinterface

[rtl/bpa_rsp_if.sv]
// Response channel of the bitmap page allocator: valid, ready and one result beat.
// Depends on bpa_pkg.
interface bpa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bpa_pkg::PAGE_W-1:0]     result_page;
   bpa_pkg::status_type            status;
   logic [bpa_pkg::CNT_W-1:0]      free_count;
   logic [bpa_pkg::CNT_W-1:0]      total_count;

   modport source (output valid, output result_page, output status, output free_count,
                   output total_count, input ready);
   modport sink   (input valid, input result_page, input status, input free_count,
                   input total_count, output ready);
endinterface

[rtl/bpa_ffs.sv]
// Shared find-first-set unit: lowest set bit of a 64-bit word.
// Depends on bpa_pkg.
module bpa_ffs (
   input  logic [bpa_pkg::LANE_W-1:0] vec,
   output logic                       found,
   output logic [bpa_pkg::BIT_W-1:0]  index
);
   import bpa_pkg::*;

   always_comb begin
      found = |vec;
      index = '0;
      for (int i = LANE_W - 1; i >= 0; i--) begin
         if (vec[i]) begin
            index = BIT_W'(i);
         end
      end
   end
endmodule

[rtl/bpa_map_store.sv]
// Free map (one bit per page, set = free) and its summary rows, with registered reads.
// Depends on bpa_pkg.
module bpa_map_store (
   input  logic                        clock,
   input  logic [bpa_pkg::WORD_W-1:0]  word_addr,
   input  bpa_pkg::store_wr_type       wr,
   output bpa_pkg::store_rd_type       rd
);
   import bpa_pkg::*;

   logic [LANE_W-1:0] map_mem [MAP_WORDS];
   logic [LANE_W-1:0] sum_mem [SUM_ROWS];
   logic [LANE_W-1:0] map_rd_ff;
   logic [LANE_W-1:0] sum_rd_ff;
   logic [ROW_W-1:0]  row_addr;

   assign row_addr = word_addr[WORD_W-1 -: ROW_W];

   // Both memories are read every cycle at the current word; a write
   // returns the old contents, which the sequencer never uses afterward.
   always_ff @(posedge clock) begin
      if (wr.we) begin
         map_mem[word_addr] <= wr.map_data;
         sum_mem[row_addr]  <= wr.sum_data;
      end
      map_rd_ff <= map_mem[word_addr];
      sum_rd_ff <= sum_mem[row_addr];
   end

   assign rd.map_word = map_rd_ff;
   assign rd.sum_word = sum_rd_ff;
endmodule

[rtl/bitmap_page_allocator.sv]
// Top level of the bitmap page allocator: the sequencer, row flags and counters.
// Depends on bpa_pkg, bpa_req_if, bpa_rsp_if, bpa_ffs and bpa_map_store.
//
//   channel  | direction | beat contents
//   ---------+-----------+------------------------------------------------------
//   req_if   | in        | action, page_number
//   rsp_if   | out       | result_page, status, free_count, total_count
//
// Free, add and reserve read the map word, apply the change and then respond;
// one whose page is out of range goes straight to the response. An allocate
// that finds a page uses the shared find-first-set unit, which scans the 256
// row flags in up to four 64-bit chunks, then one summary row, then one map
// word. An allocate that finds no free page answers after all four chunks.
// One item is in flight at a time; req_if.ready is high in idle only, and a
// response beat holds until rsp_if.ready takes it.
// Synchronous reset marks every page used and clears both counts at once; no
// clearing pass is needed, since a clear row flag masks its summary row and
// a clear summary bit masks its map word, whatever the memories hold.
module bitmap_page_allocator (
   input  logic       clock,
   input  logic       reset,
   bpa_req_if.sink    req_if,
   bpa_rsp_if.source  rsp_if
);
   import bpa_pkg::*;

   // Sequencer state and item registers.
   state_type            state_ff, state_in;
   action_type           action_ff, action_in;
   logic [PAGE_W-1:0]    page_ff, page_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [CHUNK_W-1:0]   chunk_ff, chunk_in;

   // Row flags: bit r is set when summary row r has any free word.
   logic [SUM_ROWS-1:0]  top_ff, top_in;

   logic [CNT_W-1:0]     free_ff, free_in;
   logic [CNT_W-1:0]     total_ff, total_in;

   logic [PAGE_W-1:0]    rsp_page_ff, rsp_page_in;
   status_type           rsp_status_ff, rsp_status_in;

   store_wr_type         st_wr;
   store_rd_type         st_rd;

   logic [LANE_W-1:0]    ffs_vec;
   logic                 ffs_found;
   logic [BIT_W-1:0]     ffs_index;

   logic [ROW_W-1:0]     row;
   logic [COL_W-1:0]     col;
   logic [LANE_W-1:0]    sum_eff;
   logic [LANE_W-1:0]    map_eff;
   logic [LANE_W-1:0]    bit_mask;
   logic [LANE_W-1:0]    col_mask;
   logic [LANE_W-1:0]    map_new;
   logic [LANE_W-1:0]    sum_new;
   logic                 page_free;
   logic                 make_free;
   logic                 do_write;
   logic [CNT_W-1:0]     free_up;
   logic [CNT_W-1:0]     free_down;
   logic [CNT_W-1:0]     total_up;
   logic                 in_range;

   bpa_map_store u_store (
      .clock     (clock),
      .word_addr (word_ff),
      .wr        (st_wr),
      .rd        (st_rd)
   );

   bpa_ffs u_ffs (
      .vec   (ffs_vec),
      .found (ffs_found),
      .index (ffs_index)
   );

   assign row = word_ff[WORD_W-1 -: ROW_W];
   assign col = word_ff[COL_W-1:0];

   // Masked views of the stored words, so stale memory contents never leak.
   assign sum_eff = top_ff[row] ? st_rd.sum_word : '0;
   assign map_eff = sum_eff[col] ? st_rd.map_word : '0;

   assign bit_mask  = LANE_W'(1) << bit_ff;
   assign col_mask  = LANE_W'(1) << col;
   assign page_free = map_eff[bit_ff];
   assign make_free = (action_ff == ACT_FREE) || (action_ff == ACT_ADD);
   assign map_new   = make_free ? (map_eff | bit_mask) : (map_eff & ~bit_mask);
   assign sum_new   = (map_new != '0) ? (sum_eff | col_mask) : (sum_eff & ~col_mask);

   assign free_up   = (free_ff >= NUM_PAGES_C) ? NUM_PAGES_C : free_ff + CNT_W'(1);
   assign free_down = (free_ff == '0) ? '0 : free_ff - CNT_W'(1);
   assign total_up  = (total_ff >= NUM_PAGES_C) ? NUM_PAGES_C : total_ff + CNT_W'(1);
   assign in_range  = {1'b0, req_if.page_number} < NUM_PAGES_C;

   always_comb begin
      unique case (action_ff)
         ACT_ALLOC:   do_write = 1'b1;
         ACT_FREE:    do_write = !page_free;
         ACT_ADD:     do_write = 1'b1;
         ACT_RESERVE: do_write = page_free;
         default:     do_write = 1'b0;
      endcase
   end

   // The one find-first-set unit serves three steps of an allocation.
   always_comb begin
      unique case (state_ff)
         S_TOP:   ffs_vec = top_ff[chunk_ff * LANE_W +: LANE_W];
         S_SUMF:  ffs_vec = sum_eff;
         S_MAPF:  ffs_vec = map_eff;
         default: ffs_vec = '0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      page_in       = page_ff;
      word_in       = word_ff;
      bit_in        = bit_ff;
      chunk_in      = chunk_ff;
      top_in        = top_ff;
      free_in       = free_ff;
      total_in      = total_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      st_wr.we       = 1'b0;
      st_wr.map_data = map_new;
      st_wr.sum_data = sum_new;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               action_in = req_if.action;
               page_in   = req_if.page_number;
               chunk_in  = '0;
               if (req_if.action == ACT_ALLOC) begin
                  state_in = S_TOP;
               end else if (!in_range) begin
                  rsp_page_in   = req_if.page_number;
                  rsp_status_in = ST_RANGE;
                  state_in      = S_RESP;
               end else begin
                  word_in  = req_if.page_number[PAGE_W-1:BIT_W];
                  bit_in   = req_if.page_number[BIT_W-1:0];
                  state_in = S_MAPW;
               end
            end
         end
         S_TOP: begin
            // Look for the first summary row that holds a free word.
            if (ffs_found) begin
               word_in  = {chunk_ff, ffs_index, {COL_W{1'b0}}};
               state_in = S_SUMW;
            end else if (chunk_ff == {CHUNK_W{1'b1}}) begin
               rsp_page_in   = '0;
               rsp_status_in = ST_OOM;
               state_in      = S_RESP;
            end else begin
               chunk_in = chunk_ff + CHUNK_W'(1);
            end
         end
         S_SUMW: begin
            state_in = S_SUMF;
         end
         S_SUMF: begin
            word_in  = {row, ffs_index};
            state_in = S_MAPW;
         end
         S_MAPW: begin
            state_in = (action_ff == ACT_ALLOC) ? S_MAPF : S_APPLY;
         end
         S_MAPF: begin
            bit_in   = ffs_index;
            state_in = S_APPLY;
         end
         S_APPLY: begin
            rsp_page_in   = (action_ff == ACT_ALLOC) ? {word_ff, bit_ff} : page_ff;
            rsp_status_in = do_write ? ST_DONE : ST_SAME;
            if (do_write) begin
               st_wr.we    = 1'b1;
               top_in[row] = (sum_new != '0);
               free_in     = make_free ? free_up : free_down;
               if (action_ff == ACT_ADD) begin
                  total_in = total_up;
               end
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_if.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         top_ff   <= '0;
         free_ff  <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
         free_ff  <= free_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      page_ff       <= page_in;
      word_ff       <= word_in;
      bit_ff        <= bit_in;
      chunk_ff      <= chunk_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_if.ready       = (state_ff == S_IDLE);
   assign rsp_if.valid       = (state_ff == S_RESP);
   assign rsp_if.result_page = rsp_page_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.free_count  = free_ff;
   assign rsp_if.total_count = total_ff;
endmodule
